[rtl/imuss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuss_pkg
// Shared types, register indexes and arithmetic helpers of the sample scaler.
// ----------------------------------------------------------------------------
package imuss_pkg;

    // register indexes on the write port
    localparam logic [2:0] REG_AXIS_MAP    = 3'd0;
    localparam logic [2:0] REG_ACCEL_SCALE = 3'd1;
    localparam logic [2:0] REG_GYRO_SCALE  = 3'd2;
    localparam logic [2:0] REG_TEMP_INV    = 3'd3;
    localparam logic [2:0] REG_TEMP_OFFSET = 3'd4;
    localparam logic [2:0] REG_CALIB_COUNT = 3'd5;

    // axis map codes
    localparam logic [1:0] AX_PLUS  = 2'd1;
    localparam logic [1:0] AX_MINUS = 2'd3;

    // quotient bits of the bias mean
    localparam int DIV_STEPS = 40;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MAP  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_LOAD = 6'b100000
    } state_t;

    // sequencer controls to the lanes and the temperature unit
    typedef struct packed {
        logic map_en;
        logic mul_en;
        logic fin;
        logic calib;
        logic upd;
        logic div_step;
        logic div_done;
    } lane_ctl_t;

    // signed sum of three counts selected by one map row
    function automatic logic signed [17:0] map_row(input logic [5:0] codes,
                                                   input logic signed [15:0] v0,
                                                   input logic signed [15:0] v1,
                                                   input logic signed [15:0] v2);
        logic signed [17:0] acc;
        logic signed [17:0] e [3];
        e[0] = 18'(v0);
        e[1] = 18'(v1);
        e[2] = 18'(v2);
        acc  = '0;
        for (int c = 0; c < 3; c++) begin
            if (codes[2*c +: 2] == AX_PLUS) acc = acc + e[c];
            else if (codes[2*c +: 2] == AX_MINUS) acc = acc - e[c];
        end
        return acc;
    endfunction

    // apply sign to a magnitude and saturate to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [41:0] mag);
        logic signed [31:0] r;
        if (!neg) r = (mag > 42'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
        else      r = (mag > 42'h080000000) ? 32'sh80000000 : $signed(-mag[31:0]);
        return r;
    endfunction

    // saturate a signed 44-bit value to 32 bits
    function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v > 44'sh0007FFFFFFF)      r = 32'sh7FFFFFFF;
        else if (v < -44'sh00080000000) r = 32'sh80000000;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/imuss_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuss_lane
// One output axis: maps and scales accel and gyro, holds bias, sum, divider.
// ----------------------------------------------------------------------------
module imuss_lane import imuss_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctl_t          ctl,
    input  logic [5:0]         codes,
    input  logic signed [15:0] acc0,
    input  logic signed [15:0] acc1,
    input  logic signed [15:0] acc2,
    input  logic signed [15:0] gyr0,
    input  logic signed [15:0] gyr1,
    input  logic signed [15:0] gyr2,
    input  logic [31:0]        accel_scale,
    input  logic [31:0]        gyro_scale,
    input  logic [7:0]         n,
    output logic signed [31:0] accel_out,
    output logic signed [31:0] gyro_out
);

    logic signed [17:0] ma, mg;
    logic               ma_neg_reg, mg_neg_reg, pa_neg_reg, pg_neg_reg;
    logic [16:0]        ma_mag_reg, mg_mag_reg;
    logic [48:0]        pa_reg, pg_reg;
    logic [49:0]        ra, rg;
    logic signed [31:0] gs;
    logic signed [31:0] bias_reg;
    logic signed [39:0] sum_reg, sum_next;
    logic [39:0]        sum_mag;
    logic [39:0]        dq_reg;
    logic [7:0]         rem_reg;
    logic [8:0]         trial;
    logic               bneg_reg;

    // axis mapping
    assign ma = map_row(codes, acc0, acc1, acc2);
    assign mg = map_row(codes, gyr0, gyr1, gyr2);

    always_ff @(posedge aclk) begin
        if (ctl.map_en) begin
            ma_neg_reg <= ma[17];
            mg_neg_reg <= mg[17];
            ma_mag_reg <= ma[17] ? 17'(-ma) : ma[16:0];
            mg_mag_reg <= mg[17] ? 17'(-mg) : mg[16:0];
        end
        if (ctl.mul_en) begin
            pa_reg     <= 49'(ma_mag_reg) * 49'(accel_scale);
            pg_reg     <= 49'(mg_mag_reg) * 49'(gyro_scale);
            pa_neg_reg <= ma_neg_reg;
            pg_neg_reg <= mg_neg_reg;
        end
    end

    // round, saturate, remove bias
    assign ra        = 50'(pa_reg) + 50'd128;
    assign rg        = 50'(pg_reg) + 50'd128;
    assign accel_out = sat_mag(pa_neg_reg, ra[49:8]);
    assign gs        = sat_mag(pg_neg_reg, rg[49:8]);
    assign gyro_out  = sat44(44'(gs) - 44'(bias_reg));
    assign sum_next  = sum_reg + 40'(gs);
    assign sum_mag   = sum_next[39] ? 40'(-sum_next) : sum_next;
    assign trial     = {rem_reg, dq_reg[39]};

    // calibration sum, shift-subtract divider and bias
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end else begin
            if (ctl.fin && ctl.calib) sum_reg <= ctl.upd ? '0 : sum_next;
            if (ctl.div_done) bias_reg <= sat_mag(bneg_reg, 42'(dq_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin && ctl.calib && ctl.upd) begin
            dq_reg   <= sum_mag + 40'(n >> 1);
            rem_reg  <= '0;
            bneg_reg <= sum_next[39];
        end else if (ctl.div_step) begin
            if (trial >= 9'(n)) begin
                rem_reg <= 8'(trial - 9'(n));
                dq_reg  <= {dq_reg[38:0], 1'b1};
            end else begin
                rem_reg <= trial[7:0];
                dq_reg  <= {dq_reg[38:0], 1'b0};
            end
        end
    end

endmodule

[rtl/imuss_temp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuss_temp
// Die temperature: (counts - offset) * inverse scale + offset.
// ----------------------------------------------------------------------------
module imuss_temp import imuss_pkg::*; (
    input  logic               aclk,
    input  lane_ctl_t          ctl,
    input  logic signed [15:0] temp_raw,
    input  logic [31:0]        temp_inv_scale,
    input  logic signed [31:0] temp_offset,
    output logic signed [31:0] temperature
);

    logic signed [33:0] d;
    logic               neg_reg, pneg_reg;
    logic [32:0]        mag_reg;
    logic [64:0]        p_reg;
    logic [65:0]        r;
    logic signed [42:0] t;

    assign d = $signed({{2{temp_raw[15]}}, temp_raw, 16'b0}) - 34'(temp_offset);

    always_ff @(posedge aclk) begin
        if (ctl.map_en) begin
            neg_reg <= d[33];
            mag_reg <= d[33] ? 33'(-d) : d[32:0];
        end
        if (ctl.mul_en) begin
            p_reg    <= 65'(mag_reg) * 65'(temp_inv_scale);
            pneg_reg <= neg_reg;
        end
    end

    // round, restore offset, saturate
    assign r           = 66'(p_reg) + 66'h800000;
    assign t           = pneg_reg ? -$signed({1'b0, r[65:24]}) : $signed({1'b0, r[65:24]});
    assign temperature = sat44(44'(t) + 44'(temp_offset));

endmodule

[rtl/imu_sample_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_sample_scaler
// Raw IMU sample to Q16.16 SI units with axis map and gyro bias calibration.
// ----------------------------------------------------------------------------
// A sample word passes the accepting cycle, then axis map, multiply, and round
// and saturate into the output register, the last step waiting until that
// register is free. These are the stages of the lane pipeline (one lane per
// output axis plus a temperature unit); it holds one sample at a time. The result
// sits in an output register, so the next sample is taken while it waits. A
// calibration sample that completes the mean runs a shift-subtract divider, one
// quotient bit per cycle, and the block holds off input until the bias is loaded.
module imu_sample_scaler import imuss_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, temp_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw
    input  logic [111:0] s_tdata,
    // cmd
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temperature
    output logic [223:0] m_tdata,
    // bias_updated
    output logic [0:0]   m_tuser
);

    state_t             state_reg, state_next;
    logic [17:0]        axis_map_reg;
    logic [31:0]        accel_scale_reg, gyro_scale_reg, temp_inv_reg;
    logic signed [31:0] temp_offset_reg;
    logic [7:0]         calib_count_reg, seen_reg, seen_inc, n;
    logic [CNT_W-1:0]   cnt_reg;
    logic [111:0]       in_reg;
    logic               cmd_reg;
    logic               out_free, fin_fire, upd;
    lane_ctl_t          ctl;
    logic signed [31:0] acc_o [3];
    logic signed [31:0] gyr_o [3];
    logic signed [31:0] temp_o;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_map_reg    <= 18'd65793;
            accel_scale_reg <= 32'd80339;
            gyro_scale_reg  <= 32'd17872;
            temp_inv_reg    <= 32'd50251;
            temp_offset_reg <= 32'sd1376256;
            calib_count_reg <= 8'd100;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_AXIS_MAP:    axis_map_reg    <= cfg_wdata[17:0];
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_wdata;
                REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_wdata;
                REG_TEMP_INV:    temp_inv_reg    <= cfg_wdata;
                REG_TEMP_OFFSET: temp_offset_reg <= $signed(cfg_wdata);
                REG_CALIB_COUNT: calib_count_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign n        = (calib_count_reg == 8'd0) ? 8'd1 : calib_count_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid || m_tready;
    assign fin_fire = (state_reg == ST_FIN) && out_free;
    assign seen_inc = seen_reg + 8'd1;
    assign upd      = cmd_reg && (seen_inc >= n);

    // lane controls
    always_comb begin
        ctl.map_en   = (state_reg == ST_MAP);
        ctl.mul_en   = (state_reg == ST_MUL);
        ctl.fin      = fin_fire;
        ctl.calib    = cmd_reg;
        ctl.upd      = upd;
        ctl.div_step = (state_reg == ST_DIV);
        ctl.div_done = (state_reg == ST_LOAD);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MAP;
            ST_MAP:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = upd ? ST_DIV : ST_IDLE;
            ST_DIV:  if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            cnt_reg   <= '0;
            m_tvalid  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV) cnt_reg <= cnt_reg + CNT_W'(1);
            else                     cnt_reg <= '0;
            if (fin_fire && cmd_reg) seen_reg <= upd ? 8'd0 : seen_inc;
            if (fin_fire)      m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg  <= s_tdata;
            cmd_reg <= s_tuser[0];
        end
    end

    // one lane per output axis
    for (genvar i = 0; i < 3; i++) begin : g_lane
        imuss_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .codes       (axis_map_reg[6*i +: 6]),
            .acc0        ($signed(in_reg[15:0])),
            .acc1        ($signed(in_reg[31:16])),
            .acc2        ($signed(in_reg[47:32])),
            .gyr0        ($signed(in_reg[79:64])),
            .gyr1        ($signed(in_reg[95:80])),
            .gyr2        ($signed(in_reg[111:96])),
            .accel_scale (accel_scale_reg),
            .gyro_scale  (gyro_scale_reg),
            .n           (n),
            .accel_out   (acc_o[i]),
            .gyro_out    (gyr_o[i])
        );
    end

    imuss_temp u_temp (
        .aclk           (aclk),
        .ctl            (ctl),
        .temp_raw       ($signed(in_reg[63:48])),
        .temp_inv_scale (temp_inv_reg),
        .temp_offset    (temp_offset_reg),
        .temperature    (temp_o)
    );

    // merge into the result word
    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_tdata <= {temp_o, gyr_o[2], gyr_o[1], gyr_o[0],
                        acc_o[2], acc_o[1], acc_o[0]};
            m_tuser <= upd;
        end
    end

endmodule

[tb/imuss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuss_checker
// Watches the write port and both stream channels of the sample scaler. It
// mirrors the register set and the calibration state, works out the result
// word for every accepted sample word and compares it with the block's output.
// ----------------------------------------------------------------------------
module imuss_checker import imuss_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [223:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    // mirrored registers
    logic [17:0]        map_reg;
    logic [31:0]        acc_scale;
    logic [31:0]        gyr_scale;
    logic [31:0]        tmp_inv;
    logic signed [31:0] tmp_off;
    logic [7:0]         cal_cnt;

    // calibration state
    longint bias [3];
    longint sums [3];
    int     seen;

    // expected words: {bias_updated, temperature .. accel_x}
    logic [224:0] scaled_q [$];

    string field_name [8] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
                              "gyro_z", "temperature", "bias_updated"};

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // a * s / 2^sh, rounded half away from zero
    function automatic longint mul_rnd(longint a, logic [31:0] s, int sh);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] p;
        neg = a < 0;
        mag = neg ? 64'(-a) : 64'(a);
        p   = mag * {32'd0, s};
        p   = (p + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint mix_row(int row, longint v0, longint v1, longint v2);
        longint v [3];
        longint r;
        logic [1:0] code;
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        r = 0;
        for (int c = 0; c < 3; c++) begin
            code = map_reg[2*(3*row+c) +: 2];
            if (code == AX_PLUS) r += v[c];
            else if (code == AX_MINUS) r -= v[c];
        end
        return r;
    endfunction

    // compute one result word and advance the calibration state
    function automatic logic [224:0] scale_sample(logic [111:0] d, logic cal);
        logic [224:0] w;
        longint a [3];
        longint g [3];
        longint gs [3];
        longint dt;
        longint q;
        longint mag;
        int n;
        bit upd;
        w = '0;
        upd = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(d[16*i +: 16]));
            g[i] = longint'($signed(d[16*(4+i) +: 16]));
        end
        for (int i = 0; i < 3; i++) begin
            w[32*i +: 32] = 32'(clamp32(mul_rnd(mix_row(i, a[0], a[1], a[2]), acc_scale, 8)));
            gs[i] = clamp32(mul_rnd(mix_row(i, g[0], g[1], g[2]), gyr_scale, 8));
            w[32*(3+i) +: 32] = 32'(clamp32(gs[i] - bias[i]));
        end
        dt = longint'($signed(d[48 +: 16])) * 65536 - longint'(tmp_off);
        w[192 +: 32] = 32'(clamp32(mul_rnd(dt, tmp_inv, 24) + longint'(tmp_off)));
        if (cal) begin
            n = (cal_cnt == 0) ? 1 : int'(cal_cnt);
            for (int i = 0; i < 3; i++) sums[i] += gs[i];
            seen = (seen + 1) & 8'hFF;
            if (seen >= n) begin
                for (int i = 0; i < 3; i++) begin
                    mag = (sums[i] < 0) ? -sums[i] : sums[i];
                    q = (mag + n / 2) / n;
                    bias[i] = clamp32((sums[i] < 0) ? -q : q);
                    sums[i] = 0;
                end
                seen = 0;
                upd = 1;
            end
        end
        w[224] = upd;
        return w;
    endfunction

    assign pending = scaled_q.size();

    always @(posedge aclk) begin
        logic [224:0] exp_w;
        logic [224:0] got_w;
        int           errs;
        if (!aresetn) begin
            map_reg   <= 18'h10101;
            acc_scale <= 32'd80339;
            gyr_scale <= 32'd17872;
            tmp_inv   <= 32'd50251;
            tmp_off   <= 32'sd1376256;
            cal_cnt   <= 8'd100;
            for (int i = 0; i < 3; i++) begin
                bias[i] = 0;
                sums[i] = 0;
            end
            seen = 0;
            fail_count <= 0;
            scaled_q.delete();
        end else begin
            // register writes (the user must write only while idle; not enforced here)
            if (cfg_we) begin
                case (cfg_addr)
                    REG_AXIS_MAP:    map_reg   <= cfg_wdata[17:0];
                    REG_ACCEL_SCALE: acc_scale <= cfg_wdata;
                    REG_GYRO_SCALE:  gyr_scale <= cfg_wdata;
                    REG_TEMP_INV:    tmp_inv   <= cfg_wdata;
                    REG_TEMP_OFFSET: tmp_off   <= $signed(cfg_wdata);
                    REG_CALIB_COUNT: cal_cnt   <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scaled_q.push_back(scale_sample(s_tdata, s_tuser[0]));
            // result word
            if (m_tvalid && m_tready) begin
                got_w = {m_tuser[0], m_tdata};
                errs  = 0;
                if (scaled_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errs = 1;
                end else begin
                    exp_w = scaled_q.pop_front();
                    for (int f = 0; f < 8; f++) begin
                        if (f < 7 ? exp_w[32*f +: 32] !== got_w[32*f +: 32]
                                  : exp_w[224] !== got_w[224]) begin
                            if (f < 7)
                                $error("%s: expected %0d, got %0d", field_name[f],
                                       $signed(exp_w[32*f +: 32]), $signed(got_w[32*f +: 32]));
                            else
                                $error("%s: expected %0d, got %0d", field_name[f],
                                       exp_w[224], got_w[224]);
                            errs++;
                        end
                    end
                end
                fail_count <= fail_count + errs;
            end
        end
    end

endmodule

[tb/imu_sample_scaler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_sample_scaler_test
// Drives the sample scaler with directed and random sample words over several
// register settings, with random gaps and stalls on both channels and one long
// output stall. A checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module imu_sample_scaler_test import imuss_pkg::*;;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           words_sent;
    bit           held;

    imu_sample_scaler u_top (.*);

    imuss_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // limit on the whole run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, one long hold-off once the run is under way
    initial begin
        int hold;
        hold = 0;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && words_sent >= 150) begin
                held = 1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else if ((words_sent / 64) % 3 == 0) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0100_0000;
            3: return $urandom;
            default: return $urandom_range(0, 2_000_000);
        endcase
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // stop offering, wait for every result and let a bias division finish
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_word(logic [111:0] d, logic c);
        int gap;
        @(negedge aclk);
        s_tdata  = d;
        s_tuser  = c;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        gap = $urandom_range(0, 19);
        if (words_sent >= 140 && words_sent < 260) gap = 0;
        else if (gap < 12) gap = 0;
        else if (gap < 19) gap = $urandom_range(1, 4);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_random(int n, int cal_pct);
        logic [111:0] d;
        for (int k = 0; k < n; k++) begin
            for (int f = 0; f < 7; f++) d[16*f +: 16] = pick_count();
            send_word(d, $urandom_range(0, 99) < cal_pct);
        end
    endtask

    task automatic random_regs();
        logic [17:0] m;
        case ($urandom_range(0, 3))
            0: m = 18'h10101;
            1: m = 18'h3FFFF;
            2: m = 18'h0;
            default: m = 18'($urandom);
        endcase
        cfg_write(REG_AXIS_MAP, {14'd0, m});
        cfg_write(REG_ACCEL_SCALE, pick_scale());
        cfg_write(REG_GYRO_SCALE, pick_scale());
        cfg_write(REG_TEMP_INV, pick_scale());
        case ($urandom_range(0, 3))
            0: cfg_write(REG_TEMP_OFFSET, 32'h8000_0000);
            1: cfg_write(REG_TEMP_OFFSET, 32'h7FFF_FFFF);
            default: cfg_write(REG_TEMP_OFFSET, $urandom);
        endcase
    endtask

    initial begin
        logic [111:0] d;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_AXIS_MAP;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        words_sent = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes at reset settings, both commands
        send_word('0, 1'b0);
        send_word({7{16'h7FFF}}, 1'b0);
        send_word({7{16'h8000}}, 1'b1);
        send_word({7{16'hFFFF}}, 1'b1);
        send_word({16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
                   16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0);
        drain();

        // short calibration, mixed-sign map with the unused code, saturating scales
        cfg_write(REG_CALIB_COUNT, 32'd3);
        cfg_write(REG_AXIS_MAP, 32'h2_F3D7);
        cfg_write(REG_GYRO_SCALE, 32'hFFFF_FFFF);
        cfg_write(REG_ACCEL_SCALE, 32'hFFFF_FFFF);
        cfg_write(REG_TEMP_INV, 32'hFFFF_FFFF);
        cfg_write(REG_TEMP_OFFSET, 32'h8000_0000);
        for (int k = 0; k < 8; k++) begin
            d = {16'h7FFF, 16'h8000, 16'(k * 4099), 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0};
            send_word(d, k != 3);
        end
        drain();

        // count zero behaves as one
        cfg_write(REG_GYRO_SCALE, 32'd17872);
        cfg_write(REG_TEMP_OFFSET, 32'h7FFF_FFFF);
        cfg_write(REG_CALIB_COUNT, 32'd0);
        send_word({7{16'h1234}}, 1'b1);
        send_word({7{16'hC001}}, 1'b1);
        send_word({7{16'h0101}}, 1'b0);
        drain();

        // random phases over several settings
        cfg_write(REG_CALIB_COUNT, 32'd1);
        random_regs();
        send_random(100, 30);
        drain();
        cfg_write(REG_CALIB_COUNT, 32'd7);
        random_regs();
        send_random(120, 60);
        drain();
        // seen count left high, then lowered below it
        cfg_write(REG_CALIB_COUNT, 32'd100);
        random_regs();
        send_random(60, 90);
        drain();
        cfg_write(REG_CALIB_COUNT, 32'd2);
        send_random(60, 50);
        drain();
        cfg_write(REG_CALIB_COUNT, 32'd255);
        random_regs();
        send_random(280, 95);
        drain();
        cfg_write(REG_CALIB_COUNT, $urandom_range(1, 20));
        random_regs();
        send_random(200, 40);

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
